// ===== rtl/deq_pkg.sv =====
package deq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;
	localparam int WORD_W     = 32;
	localparam int FILL_W     = 5;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_POP_BACK   = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_PEEK_BACK  = 3'd4,
		CMD_PEEK_FRONT = 3'd5,
		CMD_CLEAR      = 3'd6,
		CMD_COUNT      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [WORD_W-1:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_out;
		logic [FILL_W-1:0] fill_level;
		status_t           status;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic load_rd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_read;
	} dp_stat_t;

endpackage

// ===== rtl/deq_dp.sv =====
module deq_dp import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  in_item_t  in_item,
	output out_item_t out_item
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = IW + 1;
	localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rd_q;
	out_item_t     out_q;

	logic          full;
	logic          empty;
	logic [PW-1:0] sum;
	logic [PW-1:0] sum_m1;
	logic [IW-1:0] back_wr;
	logic [IW-1:0] back_rd;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] front_d;
	logic [CW-1:0] count_d;
	status_t       status_d;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          is_read;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign sum    = PW'(front_q) + PW'(count_q);
	assign sum_m1 = sum - PW'(1);

	assign back_wr   = (sum >= PW'(DEPTH)) ? IW'(sum - PW'(DEPTH)) : IW'(sum);
	assign back_rd   = (sum_m1 >= PW'(DEPTH)) ? IW'(sum_m1 - PW'(DEPTH)) : IW'(sum_m1);
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);

	assign is_read = in_item.command inside {CMD_POP_BACK, CMD_POP_FRONT,
		CMD_PEEK_BACK, CMD_PEEK_FRONT};
	assign stat.needs_read = is_read && !empty;

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = ST_OK;
		wr_en    = 1'b0;
		wr_addr  = back_wr;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		case (in_item.command)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = cmd.accept;
					count_d = count_q + CW'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = cmd.accept;
					wr_addr = front_dec;
					front_d = front_dec;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP_BACK, CMD_PEEK_BACK: begin
				rd_addr = back_rd;
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en = cmd.accept;
					if (in_item.command == CMD_POP_BACK) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			CMD_POP_FRONT, CMD_PEEK_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en = cmd.accept;
					if (in_item.command == CMD_POP_FRONT) begin
						front_d = front_inc;
						count_d = count_q - CW'(1);
					end
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_item.data_in[SW-1:0];
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.accept) begin
			out_q.data_out   <= '0;
			out_q.fill_level <= FILL_W'(count_d);
			out_q.status     <= status_d;
		end else if (cmd.load_rd) begin
			out_q.data_out <= WORD_W'(rd_q);
		end
	end

	assign out_item = out_q;

endmodule

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl import deq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall    = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign cmd.accept  = in_valid && !in_stall;
	assign cmd.load_rd = (state_q == S_READ);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && stat.needs_read) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_READ) begin
				out_valid_q <= 1'b1;
			end else if (cmd.accept && !stat.needs_read) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue held as a ring of DEPTH words.
// Input channel (in_valid/in_stall/in_item): one command transaction with a
// value; push back/front, pop back/front, peek back/front, clear, count.
// Output channel (out_valid/out_stall/out_item): exactly one result per
// command, in command order: data word, fill level after the command, status
// (ok, empty on pop/peek of an empty queue, full on push into a full queue).
// Pushes, clear, count and failed pops/peeks set out_valid in the cycle after
// acceptance; a pop or peek that reads the ring moves its word through rd_q
// and then the output register, since the ring memory has a registered read
// port. Non-reading commands are taken one per cycle while the output is not
// stalled; a reading command holds in_stall high while in S_READ.
// A new command is taken while the previous result waits, unless the output
// register is stalled; a stalled result holds and in_stall rises.
// Reset empties the queue (count and front pointer to zero) and drops any
// pending result; stored words are not cleared and need no clearing pass.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_item  (in_item),
		.out_item (out_item)
	);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_EMPTY) |->
		(out_item.data_out == '0) && (out_item.fill_level == '0))
		else $error("empty result carries data or nonzero fill");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_FULL) |-> (out_item.data_out == '0))
		else $error("full result carries data");

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && stat.needs_read |=> in_stall && !out_valid)
		else $error("read transaction did not hold off the input");

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import deq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 10;

	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] data;
		int          reps;
		bit          typed;
		out_item_t   res;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	logic [WORD_W-1:0] ring_mem [RING_DEPTH];
	logic [3:0]        ring_front;
	logic [FILL_W-1:0] ring_count;

	out_item_t pending_results [$];
	plan_row_t plan [$];
	int        errors = 0;
	int        cycles = 0;
	int        burst_left;

	double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic out_item_t deque_apply(in_item_t it);
		out_item_t  r;
		logic [3:0] pos;
		r = '0;
		r.status = ST_OK;
		case (it.command)
			CMD_PUSH_BACK: begin
				if (ring_count == RING_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = ring_front + ring_count[3:0];
					ring_mem[pos] = it.data_in;
					ring_count = ring_count + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (ring_count == RING_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_front = ring_front - 1'b1;
					ring_mem[ring_front] = it.data_in;
					ring_count = ring_count + 1'b1;
				end
			end
			CMD_POP_BACK, CMD_PEEK_BACK: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = ring_front + ring_count[3:0] - 1'b1;
					r.data_out = ring_mem[pos];
					if (it.command == CMD_POP_BACK)
						ring_count = ring_count - 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_PEEK_FRONT: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data_out = ring_mem[ring_front];
					if (it.command == CMD_POP_FRONT) begin
						ring_front = ring_front + 1'b1;
						ring_count = ring_count - 1'b1;
					end
				end
			end
			CMD_CLEAR: ring_count = '0;
			default: ;
		endcase
		r.fill_level = ring_count;
		return r;
	endfunction

	function automatic cmd_t pick_command(int mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return CMD_CLEAR;
		case (mode)
			MODE_FILL: begin
				if (roll < 62) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				if (roll < 80) return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
				if (roll < 95) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				return CMD_COUNT;
			end
			MODE_DRAIN: begin
				if (roll < 62) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				if (roll < 85) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				if (roll < 96) return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
				return CMD_COUNT;
			end
			default: return cmd_t'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic add_row(cmd_t cmd, logic [31:0] data, int reps, bit typed,
		logic [31:0] res_data, int res_fill, status_t res_status);
		plan_row_t row;
		row.cmd = cmd;
		row.data = data;
		row.reps = reps;
		row.typed = typed;
		row.res.data_out = res_data;
		row.res.fill_level = res_fill[FILL_W-1:0];
		row.res.status = res_status;
		plan.push_back(row);
	endtask

	// bursts of back-to-back transactions, usually separated by idle gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic offer(in_item_t it, bit typed, out_item_t typed_res);
		out_item_t predicted;
		pace();
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = deque_apply(it);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: data_out %h fill_level %0d status %0d",
					$realtime, out_item.data_out, out_item.fill_level, out_item.status);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_item.data_out !== exp_res.data_out) begin
					$display("%0t data_out mismatch: expected %h actual %h",
						$realtime, exp_res.data_out, out_item.data_out);
					errors++;
				end
				if (out_item.fill_level !== exp_res.fill_level) begin
					$display("%0t fill_level mismatch: expected %0d actual %0d",
						$realtime, exp_res.fill_level, out_item.fill_level);
					errors++;
				end
				if (out_item.status !== exp_res.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$realtime, exp_res.status, out_item.status);
					errors++;
				end
			end
		end
	end

	// receiver: stall density changes in phases, with two long hold-offs
	initial begin
		int rcv_cycle;
		int hold_left;
		int phase_left;
		int stall_pct;
		rcv_cycle = 0;
		hold_left = 0;
		phase_left = 0;
		stall_pct = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			rcv_cycle++;
			if (rcv_cycle == 400 || rcv_cycle == 4000)
				hold_left = 120;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 60;
						default: stall_pct = 90;
					endcase
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		in_item_t  it;
		out_item_t typed_res;
		int        mode;
		int        mode_left;
		burst_left = 0;
		ring_front = '0;
		ring_count = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;

		add_row(CMD_POP_BACK,   32'h0,        1, 1, 32'h0,        0,  ST_EMPTY);
		add_row(CMD_POP_FRONT,  32'h0,        1, 1, 32'h0,        0,  ST_EMPTY);
		add_row(CMD_PEEK_BACK,  32'hffffffff, 1, 1, 32'h0,        0,  ST_EMPTY);
		add_row(CMD_PEEK_FRONT, 32'h0,        1, 1, 32'h0,        0,  ST_EMPTY);
		add_row(CMD_COUNT,      32'h0,        1, 1, 32'h0,        0,  ST_OK);
		add_row(CMD_CLEAR,      32'h0,        1, 1, 32'h0,        0,  ST_OK);
		add_row(CMD_PUSH_BACK,  32'hffffffff, 1, 1, 32'h0,        1,  ST_OK);
		add_row(CMD_PUSH_FRONT, 32'h0,        1, 1, 32'h0,        2,  ST_OK);
		add_row(CMD_PEEK_BACK,  32'h0,        1, 1, 32'hffffffff, 2,  ST_OK);
		add_row(CMD_PEEK_FRONT, 32'h0,        1, 1, 32'h0,        2,  ST_OK);
		add_row(CMD_POP_FRONT,  32'h0,        1, 1, 32'h0,        1,  ST_OK);
		add_row(CMD_POP_BACK,   32'h0,        1, 1, 32'hffffffff, 0,  ST_OK);
		// front pointer wraps below zero
		add_row(CMD_PUSH_FRONT, 32'ha5a5a5a5, 8, 0, 32'h0,        0,  ST_OK);
		add_row(CMD_PUSH_BACK,  32'h5a5a5a5a, 8, 0, 32'h0,        0,  ST_OK);
		add_row(CMD_PUSH_BACK,  32'hdeadbeef, 1, 1, 32'h0,        16, ST_FULL);
		add_row(CMD_PUSH_FRONT, 32'hffffffff, 1, 1, 32'h0,        16, ST_FULL);
		add_row(CMD_COUNT,      32'h0,        1, 1, 32'h0,        16, ST_OK);
		add_row(CMD_POP_FRONT,  32'h0,        1, 0, 32'h0,        0,  ST_OK);
		add_row(CMD_POP_BACK,   32'h0,        1, 0, 32'h0,        0,  ST_OK);
		add_row(CMD_PEEK_BACK,  32'h0,        1, 0, 32'h0,        0,  ST_OK);
		add_row(CMD_CLEAR,      32'h0,        1, 1, 32'h0,        0,  ST_OK);
		add_row(CMD_PEEK_BACK,  32'h0,        1, 1, 32'h0,        0,  ST_EMPTY);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				it.command = plan[i].cmd;
				it.data_in = plan[i].data + k;
				offer(it, plan[i].typed, plan[i].res);
			end
		end

		mode = MODE_MIXED;
		mode_left = 0;
		typed_res = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
				mode_left = $urandom_range(30, 80);
			end
			mode_left--;
			it.command = pick_command(mode);
			it.data_in = pick_word();
			offer(it, 1'b0, typed_res);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
